// ----- rtl/rhci_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rhci_pkg
// shared constants and the cordic angle table for the hue/chroma/intensity core
// ---------------------------------------------------------------------------
package rhci_pkg;

	localparam int unsigned COMPONENT_BITS_DEF = 8;
	localparam int unsigned HUE_BITS_DEF       = 16;
	localparam int unsigned CORDIC_STEPS       = 32;
	localparam int unsigned ANG_W              = 32;
	localparam int unsigned OUT_W              = 16;
	localparam logic [30:0] SQRT3_Q30          = 31'd1859775393;
	localparam logic [ANG_W-1:0] QUARTER_TURN  = 32'h4000_0000;
	localparam logic [ANG_W-1:0] HALF_TURN     = 32'h8000_0000;

	// atan(2^-i) in units of 2^-32 turn, indexes 0 .. 31
	function automatic logic [ANG_W-1:0] step_angle(input logic [4:0] i);
		logic [ANG_W-1:0] a;
		begin
			case (i)
				5'd0:  a = 32'd536870912;
				5'd1:  a = 32'd316933405;
				5'd2:  a = 32'd167458907;
				5'd3:  a = 32'd85004756;
				5'd4:  a = 32'd42667331;
				5'd5:  a = 32'd21354465;
				5'd6:  a = 32'd10679838;
				5'd7:  a = 32'd5340245;
				5'd8:  a = 32'd2670163;
				5'd9:  a = 32'd1335087;
				5'd10: a = 32'd667544;
				5'd11: a = 32'd333772;
				5'd12: a = 32'd166886;
				5'd13: a = 32'd83443;
				5'd14: a = 32'd41721;
				5'd15: a = 32'd20860;
				5'd16: a = 32'd10430;
				5'd17: a = 32'd5215;
				5'd18: a = 32'd2607;
				5'd19: a = 32'd1303;
				5'd20: a = 32'd651;
				5'd21: a = 32'd325;
				5'd22: a = 32'd162;
				5'd23: a = 32'd81;
				5'd24: a = 32'd40;
				5'd25: a = 32'd20;
				5'd26: a = 32'd10;
				5'd27: a = 32'd5;
				5'd28: a = 32'd2;
				5'd29: a = 32'd1;
				default: a = 32'd0;
			endcase
			return a;
		end
	endfunction

	// per-item flags that ride alongside the cordic vector
	typedef struct packed {
		logic defined;
		logic fixed;      // hue settled without rotation
		logic d_zero;     // green equals blue
		logic a_neg;
		logic d_neg;
	} hue_ctl_t;

endpackage

// ----- rtl/rhci_cordic_stage.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rhci_cordic_stage
// one registered vectoring step of the hue cordic
// ---------------------------------------------------------------------------
module rhci_cordic_stage import rhci_pkg::*; #(
	parameter int unsigned STEP = 0,
	parameter int unsigned VEC_W = 44,
	parameter int unsigned PASS_W = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [VEC_W-1:0]  x_in,
	input  logic signed [VEC_W-1:0]  y_in,
	input  logic signed [ANG_W:0]    z_in,
	input  logic [PASS_W-1:0]        pass_in,
	output logic                     out_valid,
	output logic signed [VEC_W-1:0]  x_out,
	output logic signed [VEC_W-1:0]  y_out,
	output logic signed [ANG_W:0]    z_out,
	output logic [PASS_W-1:0]        pass_out
);

	localparam logic [4:0] STEP_IDX = 5'(STEP);

	logic signed [VEC_W-1:0] dx, dy;
	logic signed [ANG_W:0]   at;

	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;
	assign at = $signed({1'b0, step_angle(STEP_IDX)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[VEC_W-1]) begin
				x_out <= x_in + dx;
				y_out <= y_in - dy;
				z_out <= z_in + at;
			end else begin
				x_out <= x_in - dx;
				y_out <= y_in + dy;
				z_out <= z_in - at;
			end
			pass_out <= pass_in;
		end
	end

endmodule

// ----- rtl/rhci_sqrt_stage.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rhci_sqrt_stage
// one registered restoring step of the chroma square root
// ---------------------------------------------------------------------------
module rhci_sqrt_stage #(
	parameter int unsigned RAD_W = 34,
	parameter int unsigned STEP = 0
) (
	input  logic             clk,
	input  logic             en,
	input  logic [RAD_W-1:0] n_in,
	input  logic [RAD_W-1:0] res_in,
	output logic [RAD_W-1:0] n_out,
	output logic [RAD_W-1:0] res_out
);

	// bit walks down two places a step from the top even position
	localparam int unsigned TOP = (RAD_W - 2) - ((RAD_W - 2) % 2);
	localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (TOP - 2 * STEP);

	logic [RAD_W-1:0] trial;
	assign trial = res_in + BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (n_in >= trial) begin
				n_out   <= n_in - trial;
				res_out <= (res_in >> 1) + BIT;
			end else begin
				n_out   <= n_in;
				res_out <= res_in >> 1;
			end
		end
	end

endmodule

// ----- rtl/rgb_to_hue_chroma_intensity_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_to_hue_chroma_intensity_core
// rgb pixel to hue, chroma and intensity, fully pipelined
// ---------------------------------------------------------------------------
// channel  | handshake            | payload
// in       | in_valid / in_ready  | red, green, blue
// out      | out_valid / out_ready| hue_angle, hue_defined, chroma_level,
//          |                      | intensity_level
//
// one transaction per clock while the output is not stalled; a result passes
// through the input register, vector setup, one register per cordic step and the
// output register. square root and intensity ride alongside the cordic.
// reset clears every valid bit; payload registers are not reset.
// the whole pipe advances together when the output register is free or taken.
module rgb_to_hue_chroma_intensity_core import rhci_pkg::*; #(
	parameter int unsigned COMPONENT_BITS = COMPONENT_BITS_DEF,
	parameter int unsigned HUE_BITS = HUE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [COMPONENT_BITS-1:0] red,
	input  logic [COMPONENT_BITS-1:0] green,
	input  logic [COMPONENT_BITS-1:0] blue,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [OUT_W-1:0]          hue_angle,
	output logic                      hue_defined,
	output logic [OUT_W-1:0]          chroma_level,
	output logic [OUT_W-1:0]          intensity_level
);

	localparam int unsigned CB    = COMPONENT_BITS;
	localparam int unsigned A_W   = CB + 3;             // signed 2r-g-b
	localparam int unsigned VEC_W = CB + 2 + 31 + 3;    // magnitude * 2^30 plus growth
	localparam int unsigned SQ_W  = 2 * CB + 1;         // sum of squares / 2
	localparam int unsigned RAD_W = SQ_W + 16 + ((SQ_W + 16) % 2);
	localparam int unsigned NSQ   = RAD_W / 2;
	localparam int unsigned INT_W = CB + 2 + 8;
	localparam int unsigned CTL_W = $bits(hue_ctl_t);
	localparam int unsigned PASS_W = CTL_W + INT_W;
	localparam int unsigned DEPTH = CORDIC_STEPS;
	// divide by three as a reciprocal multiply, exact over INT_W-bit numerators
	localparam int unsigned DIV_SH = INT_W + 1;
	localparam logic [INT_W:0] DIV3_MUL = (INT_W+1)'(((longint'(1) << DIV_SH) + 2) / 3);

	logic adv;

	// stage 1: differences, sums and flags
	logic                   v_s1;
	logic signed [A_W-1:0]  a_s1, d_s1;
	logic [SQ_W-1:0]        sq_s1;
	logic [CB+1:0]          sum_s1;
	logic                   def_s1;

	logic signed [A_W-1:0] r_e, g_e, b_e, a_c, d_c;
	logic [CB-1:0] d1, d2, d3;
	logic [2*CB+1:0] sq_full;

	always_comb begin
		r_e = $signed({3'b000, red});
		g_e = $signed({3'b000, green});
		b_e = $signed({3'b000, blue});
		a_c = (r_e <<< 1) - g_e - b_e;
		d_c = g_e - b_e;
		d1 = (red > green) ? red - green : green - red;
		d2 = (green > blue) ? green - blue : blue - green;
		d3 = (blue > red) ? blue - red : red - blue;
		sq_full = (2*CB+2)'(d1) * (2*CB+2)'(d1) + (2*CB+2)'(d2) * (2*CB+2)'(d2)
			+ (2*CB+2)'(d3) * (2*CB+2)'(d3);
	end

	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1   <= a_c;
			d_s1   <= d_c;
			sq_s1  <= SQ_W'(sq_full >> 1);
			sum_s1 <= (CB+2)'(red) + (CB+2)'(green) + (CB+2)'(blue);
			def_s1 <= !(red == green && green == blue);
		end
	end

	// stage 2: build the cordic vector and the radicand
	logic                    v_s2;
	logic signed [VEC_W-1:0] x_s2, y_s2;
	hue_ctl_t                ctl_s2;
	logic [RAD_W-1:0]        rad_s2;
	logic [INT_W-1:0]        int_s2;

	logic [A_W-1:0] a_abs, d_abs;
	logic [A_W+30:0] y_prod;
	logic [INT_W-1:0] int_num;
	logic [2*INT_W:0] int_prod;
	assign a_abs = a_s1[A_W-1] ? A_W'(-a_s1) : A_W'(a_s1);
	assign d_abs = d_s1[A_W-1] ? A_W'(-d_s1) : A_W'(d_s1);
	assign y_prod = (A_W+31)'(d_abs) * (A_W+31)'(SQRT3_Q30);
	assign int_num = {sum_s1, 8'd0} + INT_W'(1);
	assign int_prod = (2*INT_W+1)'(int_num) * (2*INT_W+1)'(DIV3_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2 <= $signed(VEC_W'({a_abs, 30'd0}));
			y_s2 <= $signed(VEC_W'(y_prod));
			ctl_s2.defined <= def_s1;
			ctl_s2.fixed   <= (d_s1 == '0) || (a_s1 == '0);
			ctl_s2.d_zero  <= (d_s1 == '0);
			ctl_s2.a_neg   <= a_s1[A_W-1];
			ctl_s2.d_neg   <= d_s1[A_W-1];
			rad_s2 <= RAD_W'({sq_s1, 16'd0});
			int_s2 <= INT_W'(int_prod >> DIV_SH);
		end
	end

	// cordic chain, square root steps run alongside in the first NSQ stages
	logic                    cv   [DEPTH+1];
	logic signed [VEC_W-1:0] cx   [DEPTH+1];
	logic signed [VEC_W-1:0] cy   [DEPTH+1];
	logic signed [ANG_W:0]   cz   [DEPTH+1];
	logic [PASS_W-1:0]       cp   [DEPTH+1];
	logic [RAD_W-1:0]        sn   [DEPTH+1];
	logic [RAD_W-1:0]        sr   [DEPTH+1];

	assign cv[0] = v_s2;
	assign cx[0] = x_s2;
	assign cy[0] = y_s2;
	assign cz[0] = '0;
	assign cp[0] = {ctl_s2, int_s2};
	assign sn[0] = rad_s2;
	assign sr[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_step
		if (i < NSQ) begin : g_sq
			rhci_sqrt_stage #(.RAD_W(RAD_W), .STEP(i)) u_sq (
				.clk(clk), .en(adv),
				.n_in(sn[i]), .res_in(sr[i]),
				.n_out(sn[i+1]), .res_out(sr[i+1])
			);
		end else begin : g_nsq
			// beyond the square root steps the pair just rides along
			logic [RAD_W-1:0] n_q, r_q;
			always_ff @(posedge clk) begin
				if (adv) begin
					n_q <= sn[i];
					r_q <= sr[i];
				end
			end
			assign sn[i+1] = n_q;
			assign sr[i+1] = r_q;
		end
		rhci_cordic_stage #(.STEP(i), .VEC_W(VEC_W), .PASS_W(PASS_W)) u_cs (
			.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(cv[i]),
			.x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]), .pass_in(cp[i]),
			.out_valid(cv[i+1]), .x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1]),
			.pass_out(cp[i+1])
		);
	end

	// final stage: quadrant, rounding, saturation
	hue_ctl_t            ctl_f;
	logic [RAD_W-1:0]    n_f, r_f;
	logic [INT_W-1:0]    int_f;
	logic [ANG_W-1:0]    t_f, turn_f, fix_turn, fin_turn;
	logic [ANG_W:0]      fix_sum;
	logic [RAD_W:0]      chroma_f;
	logic [HUE_BITS-1:0] hue_c;

	assign ctl_f = hue_ctl_t'(cp[DEPTH][PASS_W-1 -: CTL_W]);
	assign int_f = cp[DEPTH][INT_W-1:0];
	assign n_f   = sn[DEPTH];
	assign r_f   = sr[DEPTH];

	always_comb begin
		if (cz[DEPTH][ANG_W]) begin
			t_f = '0;
		end else if (cz[DEPTH][ANG_W-1:0] > QUARTER_TURN) begin
			t_f = QUARTER_TURN;
		end else begin
			t_f = cz[DEPTH][ANG_W-1:0];
		end
		turn_f = '0;
		if (!ctl_f.a_neg && !ctl_f.d_neg) begin
			turn_f = t_f;
		end else if (ctl_f.a_neg && !ctl_f.d_neg) begin
			turn_f = HALF_TURN - t_f;
		end else if (ctl_f.a_neg) begin
			turn_f = HALF_TURN + t_f;
		end else begin
			turn_f = ANG_W'(0) - t_f;
		end
		chroma_f = (RAD_W+1)'(r_f) + ((n_f > r_f) ? (RAD_W+1)'(1) : '0);
	end

	// fixed cases: hue chosen from the sign flags and the d_zero flag only
	always_comb begin
		fix_turn = '0;
		if (!ctl_f.a_neg && !ctl_f.d_neg) begin
			fix_turn = ctl_f.d_zero ? '0 : QUARTER_TURN;
		end else if (ctl_f.a_neg && !ctl_f.d_neg) begin
			fix_turn = ctl_f.d_zero ? HALF_TURN : QUARTER_TURN;
		end else if (ctl_f.a_neg) begin
			fix_turn = ctl_f.d_zero ? HALF_TURN : QUARTER_TURN * 3;
		end else begin
			fix_turn = QUARTER_TURN * 3;
		end
	end

	assign fin_turn = ctl_f.fixed ? fix_turn : turn_f;
	assign fix_sum  = (ANG_W+1)'(fin_turn) + ((ANG_W+1)'(1) << (31 - HUE_BITS));
	assign hue_c    = fix_sum[ANG_W-1 -: HUE_BITS];

	logic out_v_q;
	assign adv = !out_v_q || out_ready;
	assign out_valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= cv[DEPTH];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_angle       <= ctl_f.defined ? OUT_W'(hue_c) : '0;
			hue_defined     <= ctl_f.defined;
			chroma_level    <= (chroma_f > (RAD_W+1)'(16'hFFFF)) ? 16'hFFFF : OUT_W'(chroma_f);
			intensity_level <= (int_f > INT_W'(16'hFFFF)) ? 16'hFFFF : OUT_W'(int_f);
		end
	end

	a_gray_no_hue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hue_defined |-> hue_angle == '0 && chroma_level == '0)
		else $error("gray pixel with hue or chroma");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hue_angle) && $stable(chroma_level))
		else $error("result changed during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipe stalled with empty output");

endmodule
